### hdl/look_at_view_matrix_macros.svh
// Assertion macros for the look-at matrix block
`ifndef LOOK_AT_VIEW_MATRIX_MACROS_SVH
`define LOOK_AT_VIEW_MATRIX_MACROS_SVH
`ifndef SYNTHESIS
`define LAV_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("look-at matrix check failed");
`define LAV_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("look-at matrix check failed");
`define LAV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("look-at matrix check failed");
`else
`define LAV_ASSERT_NEVER(lbl, cond)
`define LAV_ASSERT_IMPLY(lbl, ante, cons)
`define LAV_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hdl/lav_pkg.sv
// Types, row codes and saturation helpers shared by the look-at matrix block
package lav_pkg;

    localparam int WORD_W = 32;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [WORD_W+1:0] wide_t;

    localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
    localparam word_t WORD_MIN = 32'sh8000_0000;

    localparam logic [1:0] ROW_RIGHT = 2'd0;
    localparam logic [1:0] ROW_UP    = 2'd1;
    localparam logic [1:0] ROW_FWD   = 2'd2;
    localparam logic [1:0] ROW_POS   = 2'd3;

    typedef struct packed {
        word_t eye_x;
        word_t eye_y;
        word_t eye_z;
        word_t aim_x;
        word_t aim_y;
        word_t aim_z;
        word_t upward_x;
        word_t upward_y;
        word_t upward_z;
    } item_t;

    typedef struct packed {
        logic [1:0] row_number;
        word_t      elem_0;
        word_t      elem_1;
        word_t      elem_2;
        word_t      elem_3;
        logic       degenerate;
        logic       last_row;
    } result_t;

    // Classified request as held in the queue: eye, direction and up vectors
    typedef struct packed {
        word_t [2:0] eye;
        word_t [2:0] dir;
        word_t [2:0] upv;
    } work_t;

    function automatic wide_t widen(input word_t v);
        return {{2{v[WORD_W-1]}}, v};
    endfunction

    // Clamp a widened sum to the signed word range
    function automatic word_t sat_word(input wide_t v);
        word_t r;
        if (!v[WORD_W+1] && (v[WORD_W:WORD_W-1] != 2'b00))
            r = WORD_MAX;
        else if (v[WORD_W+1] && (v[WORD_W:WORD_W-1] != 2'b11))
            r = WORD_MIN;
        else
            r = v[WORD_W-1:0];
        return r;
    endfunction

endpackage

### hdl/look_at_view_matrix.sv
// Each vector is normalised by a left shift of s places (0..31), squaring, a square root and
// a divide; a zero vector skips this and marks the result degenerate.
// Requests are processed one at a time, each through the shared multiplier, bit-serial square
// root and restoring divider; the four rows are emitted back to back.
// Two requests queue behind the one in progress; the receiver cannot stall rows.
// Reset clears the queue and sequencer; no clearing pass is needed.
`include "look_at_view_matrix_macros.svh"
module look_at_view_matrix #(
    parameter int FRAC_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  lav_pkg::item_t   item,
    output logic             busy,
    output logic             valid,
    output lav_pkg::result_t result
);
    import lav_pkg::*;

    logic  push;
    logic  full;
    logic  pop;
    logic  nonempty;
    work_t work_in;
    work_t work_out;

    // Classify incoming requests
    lav_front u_front (
        .start (start),
        .item  (item),
        .full  (full),
        .busy  (busy),
        .push  (push),
        .work  (work_in)
    );

    // Buffer between front and back
    lav_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wdata    (work_in),
        .full     (full),
        .pop      (pop),
        .nonempty (nonempty),
        .rdata    (work_out)
    );

    // Compute and emit matrix rows
    lav_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .work_valid (nonempty),
        .work       (work_out),
        .pop        (pop),
        .valid      (valid),
        .result     (result)
    );

    `LAV_ASSERT_NEVER(a_pop_empty, pop && !nonempty)
    `LAV_ASSERT_NEXT(a_rows_run, valid && (result.row_number != ROW_POS),
        valid && (result.row_number == $past(result.row_number) + 2'd1))
    `LAV_ASSERT_IMPLY(a_col3_zero, valid && !result.last_row, result.elem_3 == '0)

endmodule

### hdl/lav_front.sv
// Front end: takes a request and forms the saturated view direction
module lav_front (
    input  logic           start,
    input  lav_pkg::item_t item,
    input  logic           full,
    output logic           busy,
    output logic           push,
    output lav_pkg::work_t work
);
    import lav_pkg::*;

    // Accept while the queue has room
    assign busy = full;
    assign push = start && !full;

    // Form direction = aim - eye with saturation
    always_comb
    begin
        work.eye[0] = item.eye_x;
        work.eye[1] = item.eye_y;
        work.eye[2] = item.eye_z;
        work.upv[0] = item.upward_x;
        work.upv[1] = item.upward_y;
        work.upv[2] = item.upward_z;
        work.dir[0] = sat_word(widen(item.aim_x) - widen(item.eye_x));
        work.dir[1] = sat_word(widen(item.aim_y) - widen(item.eye_y));
        work.dir[2] = sat_word(widen(item.aim_z) - widen(item.eye_z));
    end

endmodule

### hdl/lav_queue.sv
// Two-entry request queue between front and back ends
module lav_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lav_pkg::work_t wdata,
    output logic           full,
    input  logic           pop,
    output logic           nonempty,
    output lav_pkg::work_t rdata
);
    import lav_pkg::*;

    work_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'd2);
    assign nonempty = (count_reg != 2'd0);
    assign rdata    = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    // Hold request payload
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wdata;
    end

endmodule

### hdl/lav_back.sv
// Back end: sequencer with shared multiplier, square root and divider
module lav_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             work_valid,
    input  lav_pkg::work_t   work,
    output logic             pop,
    output logic             valid,
    output lav_pkg::result_t result
);
    import lav_pkg::*;

    localparam int CNT_W = 5;
    localparam logic [CNT_W-1:0] LAST_PAIR  = CNT_W'(5);
    localparam logic [CNT_W-1:0] LAST_SQRT  = CNT_W'(31);
    localparam logic [CNT_W-1:0] LAST_CROSS = CNT_W'(11);
    localparam logic [CNT_W-1:0] LAST_DIV   = CNT_W'(FRAC_BITS);
    localparam logic [63:0] SQ_BIT_TOP = 64'h4000_0000_0000_0000;
    localparam logic [31:0] HALF_RANGE = 32'h4000_0000;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_NINIT  = 4'd1;
    localparam logic [3:0] ST_NSHIFT = 4'd2;
    localparam logic [3:0] ST_NSQ    = 4'd3;
    localparam logic [3:0] ST_SQRT   = 4'd4;
    localparam logic [3:0] ST_DIVI   = 4'd5;
    localparam logic [3:0] ST_DIVS   = 4'd6;
    localparam logic [3:0] ST_NDONE  = 4'd7;
    localparam logic [3:0] ST_DOT    = 4'd8;
    localparam logic [3:0] ST_NUP    = 4'd9;
    localparam logic [3:0] ST_CROSS  = 4'd10;
    localparam logic [3:0] ST_EMIT   = 4'd11;

    function automatic logic [31:0] mag(input word_t v);
        return v[WORD_W-1] ? (~v + 32'd1) : v;
    endfunction

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       idx_reg, idx_next;
    logic             pass_reg, pass_next;
    logic [1:0]       row_reg, row_next;

    word_t            eye_reg [3];
    word_t            upv_reg [3];
    word_t            fwd_reg [3];
    word_t            wv_reg  [3];
    word_t            rgt_reg [3];
    word_t            tmp_reg;
    logic [31:0]      m_reg   [3];
    logic [63:0]      sum_reg;
    logic [63:0]      sq_rem_reg;
    logic [63:0]      sq_res_reg;
    logic [63:0]      sq_bit_reg;
    logic [63:0]      prod_reg;
    logic             neg_reg;
    logic [32:0]      len_reg;
    logic [32:0]      rem_reg;
    logic [FRAC_BITS:0] dsh_reg;
    logic [FRAC_BITS:0] q_reg;
    wide_t            acc_reg;
    logic             degen_reg;

    logic [1:0]       lane;
    logic [2:0]       pair;
    logic [1:0]       nidx, fidx;
    logic [31:0]      mul_a, mul_b;
    logic             mul_neg;
    logic [63:0]      shifted;
    word_t            fx;
    logic [63:0]      sum_add;
    logic [63:0]      sq_try;
    logic             sq_take;
    logic [63:0]      sq_res_next;
    logic [33:0]      rem2;
    logic             div_take;
    logic [33:0]      rem_sub;
    logic [FRAC_BITS:0] q_next;
    word_t            q_word;
    word_t            div_val;
    wide_t            acc_add;
    word_t            nup_val;
    word_t            cross_val;
    logic             any_big;
    logic             all_zero;
    logic             load;

    assign lane = cnt_reg[2:1];
    assign pair = cnt_reg[3:1];
    assign load = pop;

    // Take the next request when idle or on the final row
    assign pop = work_valid &&
                 ((state_reg == ST_IDLE) || ((state_reg == ST_EMIT) && (row_reg == ROW_POS)));

    // Select multiplier operands for the current step
    always_comb
    begin
        nidx = 2'd0;
        fidx = 2'd0;
        case (pair)
            3'd0:    begin nidx = 2'd1; fidx = 2'd2; end
            3'd1:    begin nidx = 2'd2; fidx = 2'd1; end
            3'd2:    begin nidx = 2'd2; fidx = 2'd0; end
            3'd3:    begin nidx = 2'd0; fidx = 2'd2; end
            3'd4:    begin nidx = 2'd0; fidx = 2'd1; end
            default: begin nidx = 2'd1; fidx = 2'd0; end
        endcase
        mul_a   = 32'd0;
        mul_b   = 32'd0;
        mul_neg = 1'b0;
        case (state_reg)
            ST_NSQ:
            begin
                mul_a = m_reg[lane];
                mul_b = m_reg[lane];
            end
            ST_DOT:
            begin
                mul_a   = mag(upv_reg[lane]);
                mul_b   = mag(fwd_reg[lane]);
                mul_neg = upv_reg[lane][WORD_W-1] ^ fwd_reg[lane][WORD_W-1];
            end
            ST_NUP:
            begin
                mul_a   = mag(fwd_reg[lane]);
                mul_b   = mag(tmp_reg);
                mul_neg = fwd_reg[lane][WORD_W-1] ^ tmp_reg[WORD_W-1];
            end
            ST_CROSS:
            begin
                mul_a   = mag(wv_reg[nidx]);
                mul_b   = mag(fwd_reg[fidx]);
                mul_neg = wv_reg[nidx][WORD_W-1] ^ fwd_reg[fidx][WORD_W-1];
            end
            default:
            begin
                mul_a = 32'd0;
            end
        endcase
    end

    // Scale and saturate the registered product
    always_comb
    begin
        shifted = prod_reg >> FRAC_BITS;
        if (neg_reg)
        begin
            if ((|shifted[63:32]) || (shifted[31] && (|shifted[30:0])))
                fx = WORD_MIN;
            else
                fx = -shifted[31:0];
        end
        else
        begin
            if (|shifted[63:31])
                fx = WORD_MAX;
            else
                fx = shifted[31:0];
        end
    end

    // Datapath helpers: accumulate, root step, divide step
    always_comb
    begin
        sum_add     = sum_reg + prod_reg;
        sq_try      = sq_res_reg + sq_bit_reg;
        sq_take     = (sq_rem_reg >= sq_try);
        sq_res_next = sq_take ? ((sq_res_reg >> 1) + sq_bit_reg) : (sq_res_reg >> 1);
        rem2        = {rem_reg, dsh_reg[FRAC_BITS]};
        div_take    = (rem2 >= {1'b0, len_reg});
        rem_sub     = rem2 - {1'b0, len_reg};
        q_next      = {q_reg[FRAC_BITS-1:0], div_take};
        q_word      = {{(WORD_W-FRAC_BITS-1){1'b0}}, q_next};
        div_val     = wv_reg[idx_reg][WORD_W-1] ? -q_word : q_word;
        acc_add     = acc_reg + widen(fx);
        nup_val     = sat_word(widen(upv_reg[lane]) - widen(fx));
        cross_val   = sat_word(widen(tmp_reg) - widen(fx));
        any_big     = (m_reg[0] > HALF_RANGE) || (m_reg[1] > HALF_RANGE) ||
                      (m_reg[2] > HALF_RANGE);
        all_zero    = (wv_reg[0] == '0) && (wv_reg[1] == '0) && (wv_reg[2] == '0);
    end

    // Sequence the steps of one request
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        pass_next  = pass_reg;
        row_next   = row_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (work_valid)
                begin
                    state_next = ST_NINIT;
                    pass_next  = 1'b0;
                end
            end
            ST_NINIT:
            begin
                state_next = all_zero ? ST_NDONE : ST_NSHIFT;
            end
            ST_NSHIFT:
            begin
                if (any_big)
                begin
                    state_next = ST_NSQ;
                    cnt_next   = '0;
                end
            end
            ST_NSQ:
            begin
                if (cnt_reg == LAST_PAIR)
                begin
                    state_next = ST_SQRT;
                    cnt_next   = '0;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_SQRT:
            begin
                if (cnt_reg == LAST_SQRT)
                begin
                    state_next = ST_DIVI;
                    idx_next   = 2'd0;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_DIVI:
            begin
                state_next = ST_DIVS;
                cnt_next   = '0;
            end
            ST_DIVS:
            begin
                if (cnt_reg == LAST_DIV)
                begin
                    if (idx_reg == 2'd2)
                        state_next = ST_NDONE;
                    else
                    begin
                        state_next = ST_DIVI;
                        idx_next   = idx_reg + 2'd1;
                    end
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_NDONE:
            begin
                state_next = pass_reg ? ST_CROSS : ST_DOT;
                cnt_next   = '0;
            end
            ST_DOT:
            begin
                if (cnt_reg == LAST_PAIR)
                begin
                    state_next = ST_NUP;
                    cnt_next   = '0;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_NUP:
            begin
                if (cnt_reg == LAST_PAIR)
                begin
                    state_next = ST_NINIT;
                    pass_next  = 1'b1;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_CROSS:
            begin
                if (cnt_reg == LAST_CROSS)
                begin
                    state_next = ST_EMIT;
                    row_next   = ROW_RIGHT;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_EMIT:
            begin
                if (row_reg == ROW_POS)
                begin
                    state_next = work_valid ? ST_NINIT : ST_IDLE;
                    pass_next  = 1'b0;
                end
                else
                    row_next = row_reg + 2'd1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= 2'd0;
            pass_reg  <= 1'b0;
            row_reg   <= ROW_RIGHT;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            pass_reg  <= pass_next;
            row_reg   <= row_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        neg_reg  <= mul_neg;
        if (load)
        begin
            for (int i = 0; i < 3; i++)
            begin
                eye_reg[i] <= work.eye[i];
                upv_reg[i] <= work.upv[i];
                wv_reg[i]  <= work.dir[i];
            end
            degen_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_NINIT:
                begin
                    for (int i = 0; i < 3; i++)
                        m_reg[i] <= mag(wv_reg[i]);
                    if (all_zero)
                        degen_reg <= 1'b1;
                end
                ST_NSHIFT:
                begin
                    if (!any_big)
                    begin
                        for (int i = 0; i < 3; i++)
                            m_reg[i] <= m_reg[i] << 1;
                    end
                    sum_reg <= '0;
                end
                ST_NSQ:
                begin
                    if (cnt_reg[0])
                        sum_reg <= sum_add;
                    sq_rem_reg <= sum_add;
                    sq_res_reg <= '0;
                    sq_bit_reg <= SQ_BIT_TOP;
                end
                ST_SQRT:
                begin
                    if (sq_take)
                        sq_rem_reg <= sq_rem_reg - sq_try;
                    sq_res_reg <= sq_res_next;
                    sq_bit_reg <= sq_bit_reg >> 2;
                    len_reg    <= sq_res_next[32:0];
                end
                ST_DIVI:
                begin
                    rem_reg <= {2'b00, m_reg[idx_reg][31:1]};
                    dsh_reg <= {m_reg[idx_reg][0], {FRAC_BITS{1'b0}}};
                    q_reg   <= '0;
                end
                ST_DIVS:
                begin
                    rem_reg <= div_take ? rem_sub[32:0] : rem2[32:0];
                    dsh_reg <= dsh_reg << 1;
                    q_reg   <= q_next;
                    if (cnt_reg == LAST_DIV)
                        wv_reg[idx_reg] <= div_val;
                end
                ST_NDONE:
                begin
                    if (!pass_reg)
                    begin
                        for (int i = 0; i < 3; i++)
                            fwd_reg[i] <= wv_reg[i];
                    end
                    acc_reg <= '0;
                end
                ST_DOT:
                begin
                    if (cnt_reg[0])
                        acc_reg <= acc_add;
                    if (cnt_reg == LAST_PAIR)
                        tmp_reg <= sat_word(acc_add);
                end
                ST_NUP:
                begin
                    if (cnt_reg[0])
                        wv_reg[lane] <= nup_val;
                end
                ST_CROSS:
                begin
                    if (cnt_reg[0])
                    begin
                        if (!pair[0])
                            tmp_reg <= fx;
                        else
                            rgt_reg[pair[2:1]] <= cross_val;
                    end
                end
                default:
                begin
                    tmp_reg <= tmp_reg;
                end
            endcase
        end
    end

    // Drive the current row
    assign valid = (state_reg == ST_EMIT);

    always_comb
    begin
        result.row_number = row_reg;
        result.degenerate = degen_reg;
        result.last_row   = (row_reg == ROW_POS);
        result.elem_3     = '0;
        case (row_reg)
            ROW_RIGHT:
            begin
                result.elem_0 = rgt_reg[0];
                result.elem_1 = rgt_reg[1];
                result.elem_2 = rgt_reg[2];
            end
            ROW_UP:
            begin
                result.elem_0 = wv_reg[0];
                result.elem_1 = wv_reg[1];
                result.elem_2 = wv_reg[2];
            end
            ROW_FWD:
            begin
                result.elem_0 = fwd_reg[0];
                result.elem_1 = fwd_reg[1];
                result.elem_2 = fwd_reg[2];
            end
            default:
            begin
                result.elem_0 = eye_reg[0];
                result.elem_1 = eye_reg[1];
                result.elem_2 = eye_reg[2];
                result.elem_3 = word_t'(32'd1 << FRAC_BITS);
            end
        endcase
    end

endmodule
